[design/okvt_pkg.sv]
// Package for the ordered key/value table.
// Holds operation and status codes, fixed field widths and the cell control type.
// No dependencies.
package okvt_pkg;

  localparam int OP_W     = 2;
  localparam int KEY_ID_W = 32;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic cmp_en;
    logic shift;
    logic set_hit;
    logic append;
  } cell_ctrl_t;

endpackage

[design/ordered_key_value_table.sv]
// Ordered key/value table: a chain of entry cells kept in insertion order.
// Operations: lookup, set (update or append), delete with shift-down.
// Input channel: in_valid / in_stall with operation, key_id, value_in.
// Output channel: out_valid / out_stall with status, value_out, entry_count.
// A transfer happens at a rising edge where valid is high and stall is low.
// For each accepted item, at the accepting edge every cell compares its key
// against key_id in parallel and registers a match flag; at a later edge,
// once the output register is free, the table is updated (a delete shifts
// every later cell down by one from its neighbor) and the result is loaded
// into the output register. No new item is accepted until then; in_stall
// is high while an item is in progress. out_valid rises at the update edge.
// While out_stall holds a result, one further item may be accepted; its
// update waits until the output register is free.
// Reset (rst, synchronous, active high) empties the table and clears the
// output channel. Entry contents need no clearing: only occupied cells match.
module ordered_key_value_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [okvt_pkg::OP_W-1:0]       operation,
  input  logic [okvt_pkg::KEY_ID_W-1:0]   key_id,
  input  logic [okvt_pkg::VALUE_W-1:0]    value_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [okvt_pkg::STATUS_W-1:0]   status,
  output logic [okvt_pkg::VALUE_W-1:0]    value_out,
  output logic [okvt_pkg::COUNT_W-1:0]    entry_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int KX    = (KEY_WIDTH > okvt_pkg::KEY_ID_W) ? KEY_WIDTH : okvt_pkg::KEY_ID_W;
  localparam int EXT   = (CW > okvt_pkg::COUNT_W) ? CW : okvt_pkg::COUNT_W;

  logic                          busy;
  logic [okvt_pkg::OP_W-1:0]     op_r;
  logic [KEY_WIDTH-1:0]          key_r;
  logic [VALUE_WIDTH-1:0]        value_r;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;

  logic [KX-1:0]                 key_ext;
  logic [KEY_WIDTH-1:0]          key_in;
  logic [EXT-1:0]                count_ext;

  logic                          accept;
  logic                          commit;
  logic                          hit;
  logic                          full;
  logic [IDX_W-1:0]              slot;
  logic [VALUE_WIDTH-1:0]        found;
  logic [okvt_pkg::STATUS_W-1:0] status_next;
  logic [okvt_pkg::VALUE_W-1:0]  value_out_next;

  okvt_pkg::cell_ctrl_t          ctrl;

  logic [CAPACITY-1:0]           match;
  logic [KEY_WIDTH-1:0]          keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0]        values [CAPACITY];
  logic [KEY_WIDTH-1:0]          nbr_keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0]        nbr_values [CAPACITY];

  assign key_ext   = KX'(key_id);
  assign key_in    = key_ext[KEY_WIDTH-1:0];
  assign count_ext = EXT'(count);
  assign entry_count = count_ext[okvt_pkg::COUNT_W-1:0];

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign commit   = busy && !(out_valid && out_stall);

  assign hit  = |match;
  assign full = count == CW'(CAPACITY);

  always_comb begin
    slot  = '0;
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        slot  = slot | IDX_W'(i);
        found = found | values[i];
      end
    end
  end

  always_comb begin
    ctrl.cmp_en  = accept;
    ctrl.shift   = commit && (op_r == okvt_pkg::OP_DELETE) && hit;
    ctrl.set_hit = commit && (op_r == okvt_pkg::OP_SET) && hit;
    ctrl.append  = commit && (op_r == okvt_pkg::OP_SET) && !hit && !full;
  end

  always_comb begin
    count_next     = count;
    status_next    = okvt_pkg::ST_DONE;
    value_out_next = '0;
    case (op_r)
      okvt_pkg::OP_LOOKUP: begin
        if (hit) begin
          value_out_next = okvt_pkg::VALUE_W'(found);
        end else begin
          status_next = okvt_pkg::ST_MISSING;
        end
      end
      okvt_pkg::OP_SET: begin
        if (!hit && full) begin
          status_next = okvt_pkg::ST_FULL;
        end else if (!hit) begin
          count_next = count + CW'(1);
        end
      end
      okvt_pkg::OP_DELETE: begin
        if (hit) begin
          count_next = count - CW'(1);
        end else begin
          status_next = okvt_pkg::ST_MISSING;
        end
      end
      default: begin
        status_next = okvt_pkg::ST_DONE;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == CAPACITY - 1) begin : g_last
        assign nbr_keys[g]   = '0;
        assign nbr_values[g] = '0;
      end else begin : g_mid
        assign nbr_keys[g]   = keys[g+1];
        assign nbr_values[g] = values[g+1];
      end

      okvt_cell #(
        .INDEX       (g),
        .IDX_W       (IDX_W),
        .CW          (CW),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count),
        .slot      (slot),
        .cmp_key   (key_in),
        .wr_key    (key_r),
        .wr_value  (value_r),
        .nbr_key   (nbr_keys[g]),
        .nbr_value (nbr_values[g]),
        .key       (keys[g]),
        .value     (values[g]),
        .match     (match[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        op_r    <= operation;
        key_r   <= key_in;
        value_r <= value_in[VALUE_WIDTH-1:0];
      end else if (commit) begin
        busy <= 1'b0;
      end

      if (commit) begin
        count       <= count_next;
        out_valid   <= 1'b1;
        status      <= status_next;
        value_out   <= value_out_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(match))
    else $error("more than one cell matches the key");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.append |=> count == $past(count) + CW'(1))
    else $error("append did not grow the table");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |=> count == $past(count) - CW'(1))
    else $error("delete did not shrink the table");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (commit && status_next == okvt_pkg::ST_FULL) |-> (full && !hit))
    else $error("full status without a full table");

endmodule

[design/okvt_cell.sv]
// One entry cell of the ordered key/value table chain.
// Holds a key, a value and a match flag; on delete, a cell at or above the
// hit slot takes its upper neighbor. Depends on okvt_pkg.
module okvt_cell #(
  parameter int INDEX       = 0,
  parameter int IDX_W       = 4,
  parameter int CW          = 5,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  okvt_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]          count,
  input  logic [IDX_W-1:0]       slot,
  input  logic [KEY_WIDTH-1:0]   cmp_key,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [KEY_WIDTH-1:0]   nbr_key,
  input  logic [VALUE_WIDTH-1:0] nbr_value,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   match
);

  logic occupied;
  logic at_tail;
  logic above_slot;

  assign occupied   = CW'(INDEX) < count;
  assign at_tail    = CW'(INDEX) == count;
  assign above_slot = IDX_W'(INDEX) >= slot;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= occupied && (key == cmp_key);
    end
    if (ctrl.shift && above_slot) begin
      key   <= nbr_key;
      value <= nbr_value;
    end
    if (ctrl.set_hit && match) begin
      value <= wr_value;
    end
    if (ctrl.append && at_tail) begin
      key   <= wr_key;
      value <= wr_value;
    end
  end

endmodule

[tb/tb_top.sv]
// Testbench for ordered_key_value_table: directed and random lookup/set/delete traffic.
// Expected replies come from a behavioral copy of the table, checked in transfer order.
// Depends on okvt_pkg and the ordered_key_value_table RTL.
module tb_top;

  localparam int TABLE_DEPTH = 16;
  localparam logic [okvt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 870;
  localparam int KEY_POOL = 22;
  localparam int HOLDOFF_AT = 350;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [okvt_pkg::OP_W-1:0]     op;
    logic [okvt_pkg::KEY_ID_W-1:0] key;
    logic [okvt_pkg::VALUE_W-1:0]  value;
  } table_op_t;

  typedef struct packed {
    logic [okvt_pkg::STATUS_W-1:0] status;
    logic [okvt_pkg::VALUE_W-1:0]  value;
    logic [okvt_pkg::COUNT_W-1:0]  count;
  } table_reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [okvt_pkg::OP_W-1:0]     operation = '0;
  logic [okvt_pkg::KEY_ID_W-1:0] key_id = '0;
  logic [okvt_pkg::VALUE_W-1:0]  value_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [okvt_pkg::STATUS_W-1:0] status;
  logic [okvt_pkg::VALUE_W-1:0]  value_out;
  logic [okvt_pkg::COUNT_W-1:0]  entry_count;

  table_op_t    op_queue[$];
  table_reply_t replies_due[$];

  logic [okvt_pkg::KEY_ID_W-1:0] kv_keys [TABLE_DEPTH];
  logic [okvt_pkg::VALUE_W-1:0]  kv_values [TABLE_DEPTH];
  int kv_used = 0;

  int mismatches = 0;
  int accepted_ops = 0;
  bit in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  ordered_key_value_table #(
    .CAPACITY(TABLE_DEPTH),
    .KEY_WIDTH(okvt_pkg::KEY_ID_W),
    .VALUE_WIDTH(okvt_pkg::VALUE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .key_id(key_id),
    .value_in(value_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .value_out(value_out),
    .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  function automatic table_reply_t apply_table_op(input table_op_t req);
    table_reply_t reply;
    int slot;
    reply.status = okvt_pkg::ST_DONE;
    reply.value = '0;
    slot = -1;
    for (int i = 0; i < kv_used; i++) begin
      if (slot < 0 && kv_keys[i] == req.key) slot = i;
    end
    case (req.op)
      okvt_pkg::OP_LOOKUP: begin
        if (slot >= 0) reply.value = kv_values[slot];
        else reply.status = okvt_pkg::ST_MISSING;
      end
      okvt_pkg::OP_SET: begin
        if (slot >= 0) begin
          kv_values[slot] = req.value;
        end else if (kv_used >= TABLE_DEPTH) begin
          reply.status = okvt_pkg::ST_FULL;
        end else begin
          kv_keys[kv_used] = req.key;
          kv_values[kv_used] = req.value;
          kv_used++;
        end
      end
      okvt_pkg::OP_DELETE: begin
        if (slot >= 0) begin
          for (int j = slot; j < kv_used - 1; j++) begin
            kv_keys[j] = kv_keys[j + 1];
            kv_values[j] = kv_values[j + 1];
          end
          kv_used--;
        end else begin
          reply.status = okvt_pkg::ST_MISSING;
        end
      end
      default: ;
    endcase
    reply.count = kv_used[okvt_pkg::COUNT_W-1:0];
    return reply;
  endfunction

  // sender: bursts with random gaps; gaps are put off while the receiver holds off
  always @(negedge clk) begin : send_side
    table_op_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the offered transfer
    end else if (gap_left > 0 && holdoff_left == 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (op_queue.size() > 0) begin
      req = op_queue.pop_front();
      in_valid <= 1'b1;
      operation <= req.op;
      key_id <= req.key;
      value_in <= req.value;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall modes plus one long hold-off
  always @(negedge clk) begin : recv_side
    logic next_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && accepted_ops >= HOLDOFF_AT) begin
      out_stall <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES - 1;
      holdoff_done <= 1'b1;
    end else begin
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 9) < 7);
        default: next_stall = (stall_tick % 3 != 0);
      endcase
      out_stall <= next_stall;
      stall_tick <= stall_tick + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
    end
  end

  always @(posedge clk) begin : check_side
    table_op_t req;
    table_reply_t due;
    table_reply_t got;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req = '{operation, key_id, value_in};
        replies_due.push_back(apply_table_op(req));
        accepted_ops++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = '{status, value_out, entry_count};
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected reply: status %0d value %h count %0d",
                     got.status, got.value, got.count);
        end else begin
          due = replies_due.pop_front();
          if (got.status !== due.status || got.value !== due.value ||
              got.count !== due.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: status %0d/%0d value %h/%h count %0d/%0d",
                       due.status, got.status, due.value, got.value,
                       due.count, got.count);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [okvt_pkg::KEY_ID_W-1:0] key_pool [KEY_POOL];
    logic [okvt_pkg::KEY_ID_W-1:0] key;
    logic [okvt_pkg::VALUE_W-1:0]  value;
    logic [okvt_pkg::OP_W-1:0]     op;
    int phase;
    int phase_left;
    int roll;

    op_queue.push_back('{okvt_pkg::OP_LOOKUP, 32'h1234_5678, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_DELETE, 32'h0, 64'h0});
    op_queue.push_back('{OP_UNUSED, 32'hFFFF_FFFF, {okvt_pkg::VALUE_W{1'b1}}});
    op_queue.push_back('{okvt_pkg::OP_SET, 32'h0, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_SET, 32'hFFFF_FFFF, {okvt_pkg::VALUE_W{1'b1}}});
    op_queue.push_back('{okvt_pkg::OP_LOOKUP, 32'h0, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_SET, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0});
    for (int i = 1; i <= TABLE_DEPTH - 2; i++)
      op_queue.push_back('{okvt_pkg::OP_SET, 32'h8000_0000 | i, {$urandom, $urandom}});
    op_queue.push_back('{okvt_pkg::OP_SET, 32'h0BAD_0001, 64'h5});
    op_queue.push_back('{okvt_pkg::OP_SET, 32'hFFFF_FFFF, 64'h1});
    op_queue.push_back('{okvt_pkg::OP_DELETE, 32'h8000_0007, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_LOOKUP, 32'h8000_0008, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_DELETE, 32'h0, 64'h0});
    op_queue.push_back('{okvt_pkg::OP_DELETE, 32'h8000_000E, 64'h0});
    op_queue.push_back('{OP_UNUSED, 32'h8000_0001, 64'h7777_0000_1234_0000});

    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL; i++)
      key_pool[i] = (i < TABLE_DEPTH) ? (32'h8000_0000 | (i - 1)) : $urandom;

    phase = 0;
    phase_left = 0;
    repeat (RANDOM_OPS) begin
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (phase)
        0: op = (roll < 60) ? okvt_pkg::OP_SET : (roll < 85) ? okvt_pkg::OP_LOOKUP :
                (roll < 98) ? okvt_pkg::OP_DELETE : OP_UNUSED;
        1: op = (roll < 55) ? okvt_pkg::OP_DELETE : (roll < 80) ? okvt_pkg::OP_LOOKUP :
                (roll < 98) ? okvt_pkg::OP_SET : OP_UNUSED;
        default: op = (roll < 35) ? okvt_pkg::OP_SET : (roll < 70) ? okvt_pkg::OP_LOOKUP :
                      (roll < 98) ? okvt_pkg::OP_DELETE : OP_UNUSED;
      endcase
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                       : $urandom;
      roll = $urandom_range(0, 9);
      value = (roll == 0) ? 64'h0 : (roll == 1) ? {okvt_pkg::VALUE_W{1'b1}}
                                                : {$urandom, $urandom};
      op_queue.push_back('{op, key, value});
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && replies_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
